[rtl/core/bsc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the Bhaskara sine/cosine unit.
package bsc_pkg;

    // Pi with 60 fraction bits (truncated expansion).
    localparam logic [63:0] PI_Q60 = 64'h3243_F6A8_885A_308D;

    // Fixed widths of the external angle and result words.
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;

    // Sideband that travels with each beat down the pipeline.
    typedef struct packed {
        logic valid;
        logic neg;
    } tag_t;

    // Pi rounded half up to the given number of fraction bits.
    function automatic logic [63:0] pi_at(input int unsigned frac);
        return (PI_Q60 + (64'd1 << (59 - frac))) >> (60 - frac);
    endfunction

    // Pi/2 rounded half up to the given number of fraction bits.
    function automatic logic [63:0] half_pi_at(input int unsigned frac);
        return (PI_Q60 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

endpackage

[rtl/core/bsc_reduce.sv]
`timescale 1ns / 1ps
// Angle offset, modulo 2*pi reduction pipeline and half-turn fold.
module bsc_reduce #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         command,
    input  logic [bsc_pkg::ANGLE_W-1:0]  angle,
    output logic [ANGLE_FRAC_BITS+1:0]   x,
    output bsc_pkg::tag_t                tag
);

    localparam int QB = 30 - ANGLE_FRAC_BITS;
    localparam int XW = ANGLE_FRAC_BITS + 2;
    localparam int RW = 34;
    localparam logic [63:0] PI_A = bsc_pkg::pi_at(ANGLE_FRAC_BITS);
    localparam logic [63:0] TWO_PI = PI_A << 1;
    localparam logic [RW-1:0] PI_R = RW'(PI_A);
    // A multiple of 2*pi large enough to make every angle non-negative.
    localparam logic [RW-1:0] OFF_SIN = RW'(TWO_PI << QB);
    localparam logic [RW-1:0] OFF_COS =
        RW'((TWO_PI << QB) + bsc_pkg::half_pi_at(ANGLE_FRAC_BITS));

    logic [RW-1:0] r_next [QB+2];
    logic [RW-1:0] r_reg  [QB+2];
    logic [QB+1:0] vld_reg;
    logic [XW-1:0] x_reg;
    logic [XW-1:0] x_next;
    logic          neg_reg;
    logic          neg_next;
    logic          fold_vld_reg;

    assign r_next[0] = {{(RW-bsc_pkg::ANGLE_W){angle[bsc_pkg::ANGLE_W-1]}}, angle}
                     + (command ? OFF_COS : OFF_SIN);

    always_ff @(posedge clk)
    begin
        r_reg[0] <= r_next[0];
    end

    // One conditional subtraction of 2*pi scaled by a power of two per stage.
    for (genvar k = 0; k <= QB; k++)
    begin : g_step
        localparam logic [RW-1:0] SUB = RW'(TWO_PI << (QB - k));

        assign r_next[k+1] = (r_reg[k] >= SUB) ? (r_reg[k] - SUB) : r_reg[k];

        always_ff @(posedge clk)
        begin
            r_reg[k+1] <= r_next[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            fold_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= {vld_reg[QB:0], in_valid};
            fold_vld_reg <= vld_reg[QB+1];
        end
    end

    // Fold [pi, 2*pi) onto [0, pi) and remember the sign flip.
    assign neg_next = r_reg[QB+1] >= PI_R;
    assign x_next   = neg_next ? XW'(r_reg[QB+1] - PI_R) : XW'(r_reg[QB+1]);

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        neg_reg <= neg_next;
    end

    assign x         = x_reg;
    assign tag.valid = fold_vld_reg;
    assign tag.neg   = neg_reg;

endmodule

[rtl/core/bsc_numden.sv]
`timescale 1ns / 1ps
// Product x*(pi - x) and the numerator and denominator of the Bhaskara ratio.
module bsc_numden #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ANGLE_FRAC_BITS+1:0]   x,
    input  bsc_pkg::tag_t                tag_in,
    output logic [2*ANGLE_FRAC_BITS+6:0] num,
    output logic [2*ANGLE_FRAC_BITS+6:0] den,
    output bsc_pkg::tag_t                tag_out
);

    localparam int XW = ANGLE_FRAC_BITS + 2;
    localparam int PW = 2 * XW;
    localparam int DW = 2 * ANGLE_FRAC_BITS + 7;
    localparam logic [63:0] PI_A = bsc_pkg::pi_at(ANGLE_FRAC_BITS);
    localparam logic [XW-1:0] PI_X = XW'(PI_A);
    localparam logic [DW-1:0] PI_SQ5 = DW'(PI_A * PI_A * 64'd5);

    logic [XW-1:0]     cx;
    logic [PW-1:0]     p_next;
    logic [PW-1:0]     p_reg;
    logic [DW-1:0]     num_next;
    logic [DW-1:0]     den_next;
    logic [DW-1:0]     num_reg;
    logic [DW-1:0]     den_reg;
    bsc_pkg::tag_t     tag1_reg;
    bsc_pkg::tag_t     tag2_reg;

    assign cx     = PI_X - x;
    assign p_next = x * cx;

    assign num_next = DW'(p_reg) << 4;
    assign den_next = PI_SQ5 - (DW'(p_reg) << 2);

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
        end
    end

    assign num     = num_reg;
    assign den     = den_reg;
    assign tag_out = tag2_reg;

endmodule

[rtl/core/bsc_divider.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider that produces one quotient bit per stage.
module bsc_divider #(
    parameter int DW = 55,
    parameter int QW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [DW-1:0] num,
    input  logic [DW-1:0] den,
    input  bsc_pkg::tag_t tag_in,
    output logic [QW-1:0] q,
    output bsc_pkg::tag_t tag_out
);

    logic [DW-1:0]     rem_sh  [QW];
    logic [DW-1:0]     den_w   [QW];
    logic [QW-1:0]     q_w     [QW];
    bsc_pkg::tag_t     tag_w   [QW];
    logic [DW-1:0]     rem_reg [QW-1];
    logic [DW-1:0]     den_reg [QW-1];
    logic [QW-1:0]     q_reg   [QW];
    bsc_pkg::tag_t     tag_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_stage
        logic ge;

        // The first stage decides the integer bit without a shift.
        if (j == 0)
        begin : g_first
            assign rem_sh[j] = num;
            assign den_w[j]  = den;
            assign q_w[j]    = '0;
            assign tag_w[j]  = tag_in;
        end
        else
        begin : g_next
            assign rem_sh[j] = rem_reg[j-1] << 1;
            assign den_w[j]  = den_reg[j-1];
            assign q_w[j]    = q_reg[j-1] << 1;
            assign tag_w[j]  = tag_reg[j-1];
        end

        assign ge = rem_sh[j] >= den_w[j];

        always_ff @(posedge clk)
        begin
            q_reg[j] <= q_w[j] | QW'(ge);
        end

        if (j < QW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[j] <= ge ? (rem_sh[j] - den_w[j]) : rem_sh[j];
                den_reg[j] <= den_w[j];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[j] <= '0;
            end
            else
            begin
                tag_reg[j] <= tag_w[j];
            end
        end
    end

    assign q       = q_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

[rtl/core/bhaskara_sine_cosine_unit.sv]
`timescale 1ns / 1ps
// Top level of the pipelined Bhaskara sine/cosine unit.
//
//  Channel   Ports                        Beat taken when
//  --------  ---------------------------  ------------------------------------
//  command   start, busy, command, angle  rising edge with start high, busy low
//  result    done, value                  rising edge that ends the done cycle
//
// One beat can enter on every clock cycle; busy is held low because nothing
// downstream can push back. Most of the pipeline depth comes from the modulo
// 2*pi reduction, which takes one compare-and-subtract stage per quotient
// bit, and from the restoring divider, which retires one quotient bit per
// stage. Reset clears the valid bits and the tags that carry them; data
// registers are left alone and no results are produced until new beats
// arrive. The receiver cannot stall, so the pipeline never holds and
// results leave in the order their commands came in.
module bhaskara_sine_cosine_unit #(
    parameter int ANGLE_FRAC_BITS  = 24,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [bsc_pkg::ANGLE_W-1:0] angle,
    output logic                               done,
    output logic signed [bsc_pkg::VALUE_W-1:0] value
);

    // Angle path widths follow the angle format.
    localparam int XW = ANGLE_FRAC_BITS + 2;
    localparam int DW = 2 * ANGLE_FRAC_BITS + 7;
    // The quotient carries an integer bit plus one guard bit for rounding.
    localparam int QW = RESULT_FRAC_BITS + 2;
    localparam int LATENCY = 38 - ANGLE_FRAC_BITS + RESULT_FRAC_BITS;
    localparam logic signed [bsc_pkg::VALUE_W-1:0] FULL_SCALE =
        bsc_pkg::VALUE_W'(64'd1 << RESULT_FRAC_BITS);

    logic                          accept;
    logic [XW-1:0]                 x;
    bsc_pkg::tag_t                 red_tag;
    logic [DW-1:0]                 num;
    logic [DW-1:0]                 den;
    bsc_pkg::tag_t                 nd_tag;
    logic [QW-1:0]                 q;
    bsc_pkg::tag_t                 div_tag;
    logic [QW:0]                   q_inc;
    logic [bsc_pkg::VALUE_W-1:0]   mag;
    logic [bsc_pkg::VALUE_W-1:0]   value_next;
    logic [bsc_pkg::VALUE_W-1:0]   value_reg;
    logic                          done_reg;

    // The unit never refuses a beat.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Cosine offset, reduction into [0, 2*pi) and fold into [0, pi).
    bsc_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(accept),
        .command (command),
        .angle   (angle),
        .x       (x),
        .tag     (red_tag)
    );

    // Numerator 16*x*(pi - x) and denominator 5*pi^2 - 4*x*(pi - x).
    bsc_numden #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_numden (
        .clk    (clk),
        .rst_n  (rst_n),
        .x      (x),
        .tag_in (red_tag),
        .num    (num),
        .den    (den),
        .tag_out(nd_tag)
    );

    // Ratio to RESULT_FRAC_BITS + 1 fraction bits, truncated.
    bsc_divider #(
        .DW(DW),
        .QW(QW)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .num    (num),
        .den    (den),
        .tag_in (nd_tag),
        .q      (q),
        .tag_out(div_tag)
    );

    // Round half up by dropping the guard bit, then apply the fold sign.
    // A folded zero negates to zero, so no negative zero can appear.
    assign q_inc      = {1'b0, q} + (QW+1)'(1);
    assign mag        = bsc_pkg::VALUE_W'(q_inc[QW:1]);
    assign value_next = div_tag.neg ? (bsc_pkg::VALUE_W'(0) - mag) : mag;

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_tag.valid;
        end
    end

    assign done  = done_reg;
    assign value = value_reg;

    // Every accepted command beat produces its result after the fixed latency.
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("result strobe missing after accepted command");

    // No result appears without a command beat the fixed latency earlier.
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result strobe without matching command");

    // The rounded ratio never exceeds one in magnitude.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (value <= FULL_SCALE) && (value >= -FULL_SCALE))
        else $error("result outside full scale");

endmodule

[test/bhaskara_sine_cosine_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the pipelined Bhaskara sine/cosine unit.
module bhaskara_sine_cosine_unit_tb;

    // The testbench predicts results at the block's default parameters.
    localparam int ANGLE_FRAC  = 24;
    localparam int RESULT_FRAC = 30;

    // Pi with 60 fraction bits. The angle-format constants are rounded half up.
    localparam logic [63:0] PI_FRAC60 = 64'h3243_F6A8_885A_308D;
    localparam longint PI_A =
        longint'((PI_FRAC60 + (64'd1 << (59 - ANGLE_FRAC))) >> (60 - ANGLE_FRAC));
    localparam longint HALF_PI_A =
        longint'((PI_FRAC60 + (64'd1 << (60 - ANGLE_FRAC))) >> (61 - ANGLE_FRAC));
    localparam longint TWO_PI_A = 2 * PI_A;

    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    // The pipeline is 44 stages deep. The drain pause leaves some slack on top.
    localparam int DRAIN_CYCLES = 60;
    // About 1300 beats are sent, a quarter of them at a 59 percent sender idle
    // rate. This limit leaves a wide margin over the length of that run.
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int RANDOM_BEATS = 1250;

    // One command beat waiting to go out, with the sender idle rate that
    // applies while it waits.
    typedef struct {
        logic                              cosine;
        logic signed [bsc_pkg::ANGLE_W-1:0] theta;
        int                                idle_pct;
    } angle_beat_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               command = CMD_SINE;
    logic signed [bsc_pkg::ANGLE_W-1:0] angle = '0;
    logic                               done;
    logic signed [bsc_pkg::VALUE_W-1:0] value;

    angle_beat_t                  pending_beats[$];
    logic [bsc_pkg::VALUE_W-1:0]  expected_values[$];

    int error_count   = 0;
    int sine_beats    = 0;
    int cosine_beats  = 0;
    int checked_count = 0;
    int negative_count = 0;
    int cycle_count   = 0;

    bhaskara_sine_cosine_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .angle   (angle),
        .done    (done),
        .value   (value)
    );

    always #5 clk = ~clk;

    // Predicts the value for one command beat. For cosine, pi/2 is added at
    // 64-bit width. The angle is then reduced modulo 2*pi with a remainder
    // that truncates toward zero, and 2*pi is added back when that remainder
    // is negative. The upper half turn is folded down with a sign flip. The
    // magnitude comes from the rational formula 16p / (5 pi^2 - 4p) with
    // p = x (pi - x). A restoring division produces one extra quotient bit,
    // which then rounds the magnitude half up.
    function automatic logic [bsc_pkg::VALUE_W-1:0] predict_bhaskara(
        input logic                               cosine,
        input logic signed [bsc_pkg::ANGLE_W-1:0] theta
    );
        longint                      reduced;
        logic                        flip;
        logic [63:0]                 prod;
        logic [63:0]                 num;
        logic [63:0]                 den;
        logic [63:0]                 rem;
        logic [63:0]                 quo;
        logic [63:0]                 mag;
        logic [bsc_pkg::VALUE_W-1:0] mag_w;
        reduced = longint'(theta);
        if (cosine)
        begin
            reduced = reduced + HALF_PI_A;
        end
        reduced = reduced % TWO_PI_A;
        if (reduced < 0)
        begin
            reduced = reduced + TWO_PI_A;
        end
        flip = 1'b0;
        if (reduced >= PI_A)
        begin
            reduced = reduced - PI_A;
            flip = 1'b1;
        end
        prod = 64'(reduced * (PI_A - reduced));
        num = prod << 4;
        den = 64'(PI_A * PI_A * 5) - (prod << 2);
        rem = num;
        quo = '0;
        if (rem >= den)
        begin
            rem = rem - den;
            quo = 64'd1;
        end
        for (int i = 0; i < RESULT_FRAC + 1; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'd1;
            end
        end
        mag = (quo + 64'd1) >> 1;
        mag_w = mag[bsc_pkg::VALUE_W-1:0];
        // A zero magnitude stays zero after a sign flip.
        return flip ? -mag_w : mag_w;
    endfunction

    task automatic add_beat(input logic cosine, input longint theta, input int idle_pct);
        angle_beat_t beat;
        beat.cosine   = cosine;
        beat.theta    = theta[bsc_pkg::ANGLE_W-1:0];
        beat.idle_pct = idle_pct;
        pending_beats.push_back(beat);
    endtask

    // Driver. A beat is taken at an edge where start is high and busy is low.
    // At that edge its expected value is queued, and then the next beat is put
    // on the ports unless the sender idles for this cycle. While busy is high
    // the current beat is held as it is.
    always @(posedge clk)
    begin
        angle_beat_t next_beat;
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_values.push_back(predict_bhaskara(command, angle));
                if (command == CMD_COSINE)
                begin
                    cosine_beats++;
                end
                else
                begin
                    sine_beats++;
                end
            end
            if (start && busy)
            begin
                // Hold the beat until the block is ready to take it.
            end
            else if (pending_beats.size() != 0 &&
                     $urandom_range(99) >= pending_beats[0].idle_pct)
            begin
                next_beat = pending_beats.pop_front();
                start   <= 1'b1;
                command <= next_beat.cosine;
                angle   <= next_beat.theta;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor. Each done cycle carries one result beat, which is checked
    // against the oldest expected value.
    always @(posedge clk)
    begin
        logic [bsc_pkg::VALUE_W-1:0] want;
        if (rst_n && done)
        begin
            if (expected_values.size() == 0)
            begin
                $error("value: result %0d arrived with no beat outstanding", $signed(value));
                error_count++;
            end
            else
            begin
                want = expected_values.pop_front();
                checked_count++;
                if (value[bsc_pkg::VALUE_W-1])
                begin
                    negative_count++;
                end
                if (value !== want)
                begin
                    $error("value: expected %0d, got %0d", $signed(want), $signed(value));
                    error_count++;
                end
            end
        end
    end

    // Watchdog for a block that stops answering.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, expected_values.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int     sel;
        int     idle_pct;
        longint theta;
        longint turns;

        // Directed beats: the ends of the angle range, both commands, and the
        // points where reduction and folding change course. These include
        // exact multiples of pi, where a zero magnitude meets a sign flip,
        // and angles one step to either side of them.
        add_beat(CMD_SINE,   0, 0);
        add_beat(CMD_COSINE, 0, 0);
        add_beat(CMD_SINE,   32'sh7FFF_FFFF, 0);
        add_beat(CMD_COSINE, 32'sh7FFF_FFFF, 0);
        add_beat(CMD_SINE,   -64'sd2147483648, 0);
        add_beat(CMD_COSINE, -64'sd2147483648, 0);
        add_beat(CMD_SINE,   -1, 0);
        add_beat(CMD_SINE,   1, 0);
        add_beat(CMD_COSINE, -1, 0);
        add_beat(CMD_SINE,   HALF_PI_A, 0);
        add_beat(CMD_SINE,   -HALF_PI_A, 0);
        add_beat(CMD_COSINE, HALF_PI_A, 0);
        add_beat(CMD_COSINE, -HALF_PI_A, 0);
        add_beat(CMD_SINE,   PI_A, 0);
        add_beat(CMD_SINE,   PI_A - 1, 0);
        add_beat(CMD_SINE,   PI_A + 1, 0);
        add_beat(CMD_SINE,   -PI_A, 0);
        add_beat(CMD_COSINE, PI_A, 0);
        add_beat(CMD_SINE,   3 * HALF_PI_A, 0);
        add_beat(CMD_SINE,   TWO_PI_A, 0);
        add_beat(CMD_SINE,   TWO_PI_A - 1, 0);
        add_beat(CMD_SINE,   -TWO_PI_A, 0);
        add_beat(CMD_COSINE, TWO_PI_A - HALF_PI_A, 0);
        add_beat(CMD_SINE,   40 * PI_A, 0);

        // Random beats in four phases of sender idling: none, 59 percent,
        // none again and 25 percent. The angles mix full-range words, values
        // close to multiples of pi/2 and values within a few turns of zero.
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            case (n * 4 / RANDOM_BEATS)
                0:       idle_pct = 0;
                1:       idle_pct = 59;
                2:       idle_pct = 0;
                default: idle_pct = 25;
            endcase
            sel = $urandom_range(9);
            if (sel < 4)
            begin
                theta = longint'($signed($urandom()));
            end
            else if (sel < 7)
            begin
                turns = longint'($urandom_range(80)) - 40;
                theta = turns * PI_A + longint'($urandom_range(8)) - 4;
                if ($urandom_range(1))
                begin
                    theta = theta + (turns < 0 ? HALF_PI_A : -HALF_PI_A);
                end
            end
            else
            begin
                theta = longint'($urandom_range(32'(8 * TWO_PI_A))) - 4 * TWO_PI_A;
            end
            add_beat(1'($urandom_range(1)), theta, idle_pct);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every beat has been taken, then until every result is in.
        while (pending_beats.size() != 0 || start)
        begin
            @(posedge clk);
        end
        while (expected_values.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_values.size() != 0)
        begin
            $error("value: %0d expected results never arrived", expected_values.size());
            error_count++;
        end

        $display("Sent %0d sine and %0d cosine beats, directed extremes and random angles,",
                 sine_beats, cosine_beats);
        $display("under four sender idle phases; %0d results checked, %0d negative.",
                 checked_count, negative_count);
        if (error_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/bsc_pkg.sv
rtl/core/bsc_reduce.sv
rtl/core/bsc_numden.sv
rtl/core/bsc_divider.sv
rtl/core/bhaskara_sine_cosine_unit.sv
test/bhaskara_sine_cosine_unit_tb.sv
